@@ design/button_click_classifier_top_defines.svh @@
// ----------------------------------------------------------------------------
// Button click classifier assertion macros
// Shared concurrent check macros, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_CLASSIFIER_TOP_DEFINES_SVH
`define BUTTON_CLICK_CLASSIFIER_TOP_DEFINES_SVH

// same-cycle implication
`define BCC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bcc check failed");

// next-cycle implication
`define BCC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bcc check failed");

`endif

@@ design/bcc_pkg.sv @@
// ----------------------------------------------------------------------------
// Button click classifier package
// Widths, register indexes, event codes and configuration struct.
// ----------------------------------------------------------------------------
package bcc_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int CFG_WIDTH   = 16;
   localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
   localparam int IDX_WIDTH   = 2;
   localparam int EV_WIDTH    = 3;
   localparam int CLK_WIDTH   = 3;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [CFG_WIDTH-1:0]   cfg_word_type;
   typedef logic [CMP_WIDTH-1:0]   cmp_type;
   typedef logic [IDX_WIDTH-1:0]   idx_type;
   typedef logic [EV_WIDTH-1:0]    event_type;
   typedef logic [CLK_WIDTH-1:0]   clicks_type;

   localparam count_type  COUNT_MAX = '1;
   localparam clicks_type CLICKS_MAX = '1;

   // register indexes
   localparam idx_type REG_NOISE_FLOOR    = 2'd0;
   localparam idx_type REG_LONG_THRESHOLD = 2'd1;
   localparam idx_type REG_NOISE_CEILING  = 2'd2;
   localparam idx_type REG_GAP_TIMEOUT    = 2'd3;

   localparam cfg_word_type RST_NOISE_FLOOR    = 16'd5;
   localparam cfg_word_type RST_LONG_THRESHOLD = 16'd50;
   localparam cfg_word_type RST_NOISE_CEILING  = 16'd300;
   localparam cfg_word_type RST_GAP_TIMEOUT    = 16'd40;

   // event codes
   localparam event_type EV_NONE   = 3'd0;
   localparam event_type EV_SINGLE = 3'd1;
   localparam event_type EV_DOUBLE = 3'd2;
   localparam event_type EV_TRIPLE = 3'd3;
   localparam event_type EV_LONG   = 3'd4;

   localparam clicks_type CLICKS_ONE   = 3'd1;
   localparam clicks_type CLICKS_TWO   = 3'd2;
   localparam clicks_type CLICKS_THREE = 3'd3;

   typedef struct packed {
      cfg_word_type noise_floor;
      cfg_word_type long_threshold;
      cfg_word_type noise_ceiling;
      cfg_word_type gap_timeout;
   } cfg_type;

   function automatic cmp_type ext_count(input count_type value);
      return CMP_WIDTH'(value);
   endfunction

   function automatic cmp_type ext_cfg(input cfg_word_type value);
      return CMP_WIDTH'(value);
   endfunction

endpackage

@@ design/bcc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Button click classifier configuration registers
// Four 16-bit threshold registers behind a plain write port.
// ----------------------------------------------------------------------------
module bcc_cfg_regs
   import bcc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         write_en,
   input  idx_type      index,
   input  cfg_word_type wdata,
   output cfg_type      cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            REG_NOISE_FLOOR:    cfg_in.noise_floor    = wdata;
            REG_LONG_THRESHOLD: cfg_in.long_threshold = wdata;
            REG_NOISE_CEILING:  cfg_in.noise_ceiling  = wdata;
            REG_GAP_TIMEOUT:    cfg_in.gap_timeout    = wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.noise_floor    <= RST_NOISE_FLOOR;
         cfg_ff.long_threshold <= RST_LONG_THRESHOLD;
         cfg_ff.noise_ceiling  <= RST_NOISE_CEILING;
         cfg_ff.gap_timeout    <= RST_GAP_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ design/bcc_core.sv @@
// ----------------------------------------------------------------------------
// Button click classifier core
// Press/release counters and the noise/click/stage phase machine.
// ----------------------------------------------------------------------------
`include "button_click_classifier_top_defines.svh"

module bcc_core
   import bcc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      step,
   input  logic      pin_level,
   output event_type click_event
);

   typedef enum logic [1:0] {
      PH_NOISE = 2'd0,
      PH_CLICK = 2'd1,
      PH_STAGE = 2'd2
   } phase_type;

   logic       last_level_ff,   last_level_in;
   phase_type  phase_ff,        phase_in;
   count_type  press_ticks_ff,  press_ticks_in;
   count_type  release_ticks_ff, release_ticks_in;
   clicks_type short_clicks_ff, short_clicks_in;

   count_type press_mid;
   count_type release_mid;
   cmp_type   press_x;
   cmp_type   release_x;
   logic      clear_seq;
   event_type ev;

   always_comb begin
      // edge clears first, then saturating count
      press_mid   = (pin_level && !last_level_ff) ? '0 : press_ticks_ff;
      release_mid = (!pin_level && last_level_ff) ? '0 : release_ticks_ff;
      if (pin_level && press_mid != COUNT_MAX) begin
         press_mid = press_mid + 1'b1;
      end
      if (!pin_level && release_mid != COUNT_MAX) begin
         release_mid = release_mid + 1'b1;
      end
      press_x   = ext_count(press_mid);
      release_x = ext_count(release_mid);

      phase_in        = phase_ff;
      short_clicks_in = short_clicks_ff;
      clear_seq       = 1'b0;
      ev              = EV_NONE;

      case (phase_ff)
         PH_CLICK: begin
            if (!pin_level) begin
               if (press_x > ext_cfg(cfg.noise_floor) &&
                   press_x <= ext_cfg(cfg.long_threshold)) begin
                  phase_in = PH_STAGE;
                  if (short_clicks_ff != CLICKS_MAX) begin
                     short_clicks_in = short_clicks_ff + 1'b1;
                  end
               end else if (press_x > ext_cfg(cfg.long_threshold) &&
                            press_x <= ext_cfg(cfg.noise_ceiling)) begin
                  clear_seq = 1'b1;
                  ev        = EV_LONG;
               end else if (press_x > ext_cfg(cfg.noise_ceiling)) begin
                  clear_seq = 1'b1;
               end
            end
         end
         PH_STAGE: begin
            if (release_x > ext_cfg(cfg.gap_timeout) && !pin_level) begin
               case (short_clicks_ff)
                  CLICKS_ONE:   ev = EV_SINGLE;
                  CLICKS_TWO:   ev = EV_DOUBLE;
                  CLICKS_THREE: ev = EV_TRIPLE;
                  default:      ev = EV_NONE;
               endcase
               clear_seq = 1'b1;
            end else if (release_x <= ext_cfg(cfg.gap_timeout) && pin_level) begin
               phase_in = PH_CLICK;
            end
         end
         default: begin
            // noise phase, unused code behaves the same
            if (press_x > ext_cfg(cfg.noise_floor) && pin_level) begin
               phase_in = PH_CLICK;
            end else if (press_x <= ext_cfg(cfg.noise_floor) && !pin_level) begin
               clear_seq = 1'b1;
            end
         end
      endcase

      press_ticks_in   = press_mid;
      release_ticks_in = release_mid;
      if (clear_seq) begin
         press_ticks_in   = '0;
         release_ticks_in = '0;
         short_clicks_in  = '0;
         phase_in         = PH_NOISE;
      end
      last_level_in = pin_level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff    <= 1'b0;
         phase_ff         <= PH_NOISE;
         press_ticks_ff   <= '0;
         release_ticks_ff <= '0;
         short_clicks_ff  <= '0;
      end else if (step) begin
         last_level_ff    <= last_level_in;
         phase_ff         <= phase_in;
         press_ticks_ff   <= press_ticks_in;
         release_ticks_ff <= release_ticks_in;
         short_clicks_ff  <= short_clicks_in;
      end
   end

   assign click_event = ev;

   // a staged sequence always holds at least one short click
   `BCC_ASSERT_NOW(a_stage_has_click, phase_ff == PH_STAGE, short_clicks_ff != '0)
   // a long click always ends the sequence
   `BCC_ASSERT_NEXT(a_long_clears, step && ev == EV_LONG, phase_ff == PH_NOISE && short_clicks_ff == '0)

endmodule

@@ design/button_click_classifier_top.sv @@
// ----------------------------------------------------------------------------
// Button click classifier top level
// Input register, classifier core, result register and threshold registers.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one button sample (req_pin_level) per request;
//   rsp channel returns one click code (rsp_click_event) per request, in
//   order: 0 none, 1 single, 2 double, 3 triple, 4 long click.
//   csr_write_en/csr_index/csr_wdata write the four thresholds; write only
//   while no request is in flight.
// Flow: a request enters the input register, then its result moves to the
//   result register when the result side is free. One request per cycle
//   sustained while rsp_stall is low; the phase machine and counters update
//   in the same cycle that the sample moves on to the result register.
// Reset: synchronous; clears the valid flags of both pipeline registers and
//   the sequence state, and loads the thresholds 5, 50, 300 and 40.
// Stall: while rsp_stall holds a result, one more request is taken into
//   the input register; req_stall then rises until the result is taken.
// ----------------------------------------------------------------------------
`include "button_click_classifier_top_defines.svh"

module button_click_classifier_top
   import bcc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_pin_level,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output event_type    rsp_click_event,
   input  logic         csr_write_en,
   input  idx_type      csr_index,
   input  cfg_word_type csr_wdata
);

   logic      in_valid_ff,  in_valid_in;
   logic      in_pin_ff,    in_pin_in;
   logic      out_valid_ff, out_valid_in;
   event_type out_event_ff, out_event_in;
   logic      accept;
   logic      advance;
   cfg_type   cfg;
   event_type core_event;

   bcc_cfg_regs u_cfg (
      .clock    (clock),
      .reset    (reset),
      .write_en (csr_write_en),
      .index    (csr_index),
      .wdata    (csr_wdata),
      .cfg      (cfg)
   );

   bcc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .step        (advance),
      .pin_level   (in_pin_ff),
      .click_event (core_event)
   );

   always_comb begin
      advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
      req_stall    = in_valid_ff && !advance;
      accept       = req_valid && !req_stall;
      in_valid_in  = accept || (in_valid_ff && !advance);
      in_pin_in    = accept ? req_pin_level : in_pin_ff;
      out_valid_in = advance || (out_valid_ff && rsp_stall);
      out_event_in = advance ? core_event : out_event_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_pin_ff    <= in_pin_in;
      out_event_ff <= out_event_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_click_event = out_event_ff;

   // a held request is never dropped
   `BCC_ASSERT_NEXT(a_hold_request, in_valid_ff && !advance, in_valid_ff)
   // request side only stalls with a full input register behind a held result
   `BCC_ASSERT_NOW(a_stall_cause, req_stall, in_valid_ff && out_valid_ff && rsp_stall)

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Button click classifier testbench
// Drives pin samples through the request channel and predicts each click
// code in a scoreboard. Covers directed click patterns and random
// press/release sequences under several threshold settings.
// Both channels idle at random, except in the last phase.
// ----------------------------------------------------------------------------
module testbench
   import bcc_pkg::*;
;

   localparam int WATCHDOG_LIMIT = 1000;

   typedef enum logic [1:0] {
      PH_NOISE = 2'd0,
      PH_CLICK = 2'd1,
      PH_STAGE = 2'd2
   } phase_type;

   class click_scoreboard;
      cfg_type   cfg;
      phase_type phase;
      logic      prev_level;
      count_type press_cnt;
      count_type release_cnt;
      clicks_type clicks;
      event_type pending_clicks[$];
      int        mismatches;

      function new();
         cfg = '{RST_NOISE_FLOOR, RST_LONG_THRESHOLD, RST_NOISE_CEILING, RST_GAP_TIMEOUT};
         prev_level = 1'b0;
         mismatches = 0;
         clear_sequence();
      endfunction

      function void clear_sequence();
         press_cnt = '0;
         release_cnt = '0;
         clicks = '0;
         phase = PH_NOISE;
      endfunction

      function void write_reg(input idx_type idx, input cfg_word_type val);
         case (idx)
            REG_NOISE_FLOOR:    cfg.noise_floor = val;
            REG_LONG_THRESHOLD: cfg.long_threshold = val;
            REG_NOISE_CEILING:  cfg.noise_ceiling = val;
            REG_GAP_TIMEOUT:    cfg.gap_timeout = val;
            default: ;
         endcase
      endfunction

      function void note_sample(input logic pin);
         event_type ev;
         ev = EV_NONE;
         if (pin && !prev_level) press_cnt = '0;
         if (!pin && prev_level) release_cnt = '0;
         if (pin) begin
            if (press_cnt != COUNT_MAX) press_cnt++;
         end else begin
            if (release_cnt != COUNT_MAX) release_cnt++;
         end
         prev_level = pin;

         case (phase)
            PH_CLICK: begin
               if (!pin) begin
                  if (press_cnt > cfg.noise_floor && press_cnt <= cfg.long_threshold) begin
                     phase = PH_STAGE;
                     if (clicks != CLICKS_MAX) clicks++;
                  end else if (press_cnt > cfg.long_threshold &&
                               press_cnt <= cfg.noise_ceiling) begin
                     clear_sequence();
                     ev = EV_LONG;
                  end else if (press_cnt > cfg.noise_ceiling) begin
                     clear_sequence();
                  end
               end
            end
            PH_STAGE: begin
               if (release_cnt > cfg.gap_timeout && !pin) begin
                  case (clicks)
                     CLICKS_ONE:   ev = EV_SINGLE;
                     CLICKS_TWO:   ev = EV_DOUBLE;
                     CLICKS_THREE: ev = EV_TRIPLE;
                     default:      ev = EV_NONE;
                  endcase
                  clear_sequence();
               end else if (release_cnt <= cfg.gap_timeout && pin) begin
                  phase = PH_CLICK;
               end
            end
            default: begin
               if (press_cnt > cfg.noise_floor && pin) begin
                  phase = PH_CLICK;
               end else if (press_cnt <= cfg.noise_floor && !pin) begin
                  clear_sequence();
               end
            end
         endcase
         pending_clicks.push_back(ev);
      endfunction

      task report_mismatch(input string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      task check_click(input event_type got);
         event_type want;
         if (pending_clicks.size() == 0) begin
            report_mismatch($sformatf("click code %0d with no request pending", got));
         end else begin
            want = pending_clicks.pop_front();
            if (got !== want)
               report_mismatch($sformatf("click code %0d, expected %0d", got, want));
         end
      endtask
   endclass

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   logic         req_pin_level = 1'b0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   event_type    rsp_click_event;
   logic         csr_write_en = 1'b0;
   idx_type      csr_index = REG_NOISE_FLOOR;
   cfg_word_type csr_wdata = '0;

   click_scoreboard sb = new();
   bit idle_on = 1'b1;
   int quiet_cycles = 0;

   button_click_classifier_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pin_level   (req_pin_level),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_click_event (rsp_click_event),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (req_valid && !req_stall) sb.note_sample(req_pin_level);
         if (rsp_valid && !rsp_stall) sb.check_click(rsp_click_event);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin : result_backpressure
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold == 0 && idle_on && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 3);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // entered and left on a falling edge; valid stays high for the next request
   task automatic send_sample(input logic pin);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pin_level <= pin;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_run(input logic pin, input int n);
      repeat (n) send_sample(pin);
   endtask

   task automatic drain_requests();
      req_valid <= 1'b0;
      while (sb.pending_clicks.size() != 0) @(posedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic apply_settings(input cfg_type s);
      idx_type      regs[4];
      cfg_word_type vals[4];
      regs = '{REG_NOISE_FLOOR, REG_LONG_THRESHOLD, REG_NOISE_CEILING, REG_GAP_TIMEOUT};
      vals = '{s.noise_floor, s.long_threshold, s.noise_ceiling, s.gap_timeout};
      for (int i = 0; i < 4; i++) begin
         @(negedge clock);
         csr_write_en <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         sb.write_reg(regs[i], vals[i]);
      end
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // favors the range ends; falls back to a short run when the range is empty or starts above 1000
   function automatic int pick_len(input int lo, input int hi);
      if (lo < 1) lo = 1;
      if (hi < lo || lo > 1000) return $urandom_range(1, 8);
      case ($urandom_range(0, 3))
         0: return lo;
         1: return (hi - lo <= 300) ? hi : lo + $urandom_range(0, 20);
         default: return lo + $urandom_range(0, (hi - lo < 20) ? hi - lo : 20);
      endcase
   endfunction

   task automatic random_traffic(input cfg_type s, input int budget);
      int sent, presses, len, gap_len, r;
      int floor_v, long_v, ceil_v, gap_v, long_lo, over_lo;
      floor_v = int'(s.noise_floor);
      long_v  = int'(s.long_threshold);
      ceil_v  = int'(s.noise_ceiling);
      gap_v   = int'(s.gap_timeout);
      long_lo = ((long_v > floor_v) ? long_v : floor_v) + 1;
      over_lo = ((ceil_v > floor_v) ? ceil_v : floor_v) + 1;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(0, 9) == 0) begin
            // pin chatter
            len = $urandom_range(1, 8);
            repeat (len) send_sample(1'($urandom_range(0, 1)));
            sent += len;
         end else begin
            presses = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
            for (int i = 0; i < presses; i++) begin
               r = $urandom_range(0, 9);
               if (r < 6)      len = pick_len(floor_v + 1, long_v);
               else if (r < 7) len = pick_len(1, floor_v);
               else if (r < 9) len = pick_len(long_lo, ceil_v);
               else            len = pick_len(over_lo, over_lo + 10);
               send_run(1'b1, len);
               if (i == presses - 1 || $urandom_range(0, 7) == 0)
                  gap_len = pick_len(gap_v + 1, gap_v + 4);
               else
                  gap_len = pick_len(1, gap_v);
               send_run(1'b0, gap_len);
               sent += len + gap_len;
            end
         end
      end
      drain_requests();
   endtask

   initial begin : stimulus
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // reset thresholds: a press too short to count
      send_run(1'b1, 3);
      send_run(1'b0, 2);
      drain_requests();

      // floor 0, long 1, ceiling 2, gap 1: single, long, too long, double, triple, four
      apply_settings('{16'd0, 16'd1, 16'd2, 16'd1});
      send_run(1'b1, 1); send_run(1'b0, 2);
      send_run(1'b1, 2); send_run(1'b0, 1);
      send_run(1'b1, 3); send_run(1'b0, 1);
      repeat (2) begin send_run(1'b1, 1); send_run(1'b0, 1); end
      send_run(1'b0, 1);
      repeat (3) begin send_run(1'b1, 1); send_run(1'b0, 1); end
      send_run(1'b0, 1);
      repeat (4) begin send_run(1'b1, 1); send_run(1'b0, 1); end
      send_run(1'b0, 1);
      drain_requests();

      apply_settings('{16'd2, 16'd8, 16'd15, 16'd6});
      random_traffic('{16'd2, 16'd8, 16'd15, 16'd6}, 300);
      apply_settings('{RST_NOISE_FLOOR, RST_LONG_THRESHOLD, RST_NOISE_CEILING, RST_GAP_TIMEOUT});
      random_traffic('{RST_NOISE_FLOOR, RST_LONG_THRESHOLD, RST_NOISE_CEILING, RST_GAP_TIMEOUT},
                     300);
      apply_settings('{16'd0, 16'd0, 16'd0, 16'd0});
      random_traffic('{16'd0, 16'd0, 16'd0, 16'd0}, 150);
      // long threshold above the ceiling
      apply_settings('{16'd4, 16'd20, 16'd10, 16'd5});
      random_traffic('{16'd4, 16'd20, 16'd10, 16'd5}, 150);
      apply_settings('{16'd3, 16'd6, 16'd10, 16'd0});
      random_traffic('{16'd3, 16'd6, 16'd10, 16'd0}, 150);
      apply_settings('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
      random_traffic('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 40);

      idle_on = 1'b0;
      apply_settings('{16'd1, 16'd4, 16'd9, 16'd3});
      random_traffic('{16'd1, 16'd4, 16'd9, 16'd3}, 200);

      repeat (4) @(posedge clock);
      if (sb.pending_clicks.size() != 0)
         sb.report_mismatch($sformatf("%0d click codes never arrived",
                                      sb.pending_clicks.size()));
      if (sb.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
